// ----- src/ptle_pkg.sv -----
// ----------------------------------------------------------------------------
// ptle_pkg: shared types and constants of the peer table leader election
// Holds the beat types, the command, role and register codes, and the
// score function that is used by the top level to score peers and self.
// ----------------------------------------------------------------------------
package ptle_pkg;

  localparam int unsigned PEER_SLOTS_DEF = 16;
  // Wide enough for a live count of up to 256 slots.
  localparam int unsigned LIVE_W    = 9;
  localparam int unsigned SCORE_W   = 18;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam logic [4:0]  LIVE_OUT_MAX = 5'd31;

  typedef enum logic [1:0] {
    CMD_ANNOUNCE = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_ELECT    = 2'd2
  } ptle_cmd_e;

  typedef enum logic [1:0] {
    ROLE_STANDALONE  = 2'd0,
    ROLE_DISCOVERING = 2'd1,
    ROLE_COORDINATOR = 2'd2,
    ROLE_WORKER      = 2'd3
  } ptle_role_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELF_ADDRESS   = 3'd0,
    REG_SELF_PORT      = 3'd1,
    REG_SELF_RAM_MB    = 3'd2,
    REG_SELF_CORES     = 3'd3,
    REG_EXPIRY_TIMEOUT = 3'd4
  } ptle_reg_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] peer_address;
    logic [15:0] peer_port;
    logic [23:0] peer_ram_mb;
    logic [9:0]  peer_cores;
  } ptle_in_t;

  typedef struct packed {
    logic [1:0]  role;
    logic [31:0] leader_address;
    logic [15:0] leader_port;
    logic [4:0]  live_peers;
    logic        topology_changed;
    logic        table_full;
  } ptle_out_t;

  // Operation broadcast to every cell while a walk is in progress.
  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        address;
    logic [15:0]        port;
    logic [SCORE_W-1:0] score;
    logic [15:0]        timeout;
    logic               fill;
  } ptle_bcast_t;

  // Token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic               active;
    logic               hit;
    logic               free_seen;
    logic               removed;
    logic [LIVE_W-1:0]  live;
    logic [SCORE_W-1:0] lead_score;
    logic [31:0]        best_address;
    logic [15:0]        best_port;
  } ptle_tok_t;

  // Score is (ram / 1024) * 10 + cores, with the multiply done as two shifts.
  function automatic logic [SCORE_W-1:0] score_of(input logic [23:0] ram_mb,
                                                  input logic [9:0]  cores);
    logic [13:0] gb;
    gb = ram_mb[23:10];
    return {1'b0, gb, 3'b000} + {3'b000, gb, 1'b0} + {8'b0, cores};
  endfunction

endpackage

// ----- src/ptle_cell.sv -----
// ----------------------------------------------------------------------------
// ptle_cell: one slot of the peer table
// Holds one peer entry and applies the current operation to it when the
// walking token passes, then hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module ptle_cell import ptle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ptle_bcast_t bcast_i,
  input  ptle_tok_t   tok_i,
  output ptle_tok_t   tok_o
);

  logic               valid_q, valid_d;
  logic               first_free_q, first_free_d;
  logic [31:0]        address_q;
  logic [15:0]        port_q;
  logic [SCORE_W-1:0] score_q;
  logic [15:0]        age_q, age_d;
  logic               write_entry;
  logic [15:0]        age_inc;
  logic               match;
  ptle_tok_t          tok_q, tok_d;

  assign age_inc = (age_q == AGE_MAX) ? age_q : age_q + 16'd1;
  assign match   = valid_q && (address_q == bcast_i.address) && (port_q == bcast_i.port);

  always_comb begin
    tok_d        = tok_i;
    valid_d      = valid_q;
    first_free_d = first_free_q;
    age_d        = age_q;
    write_entry  = 1'b0;

    // The end-of-walk fill targets the first free slot of the last announce.
    if (bcast_i.fill && first_free_q) begin
      write_entry = 1'b1;
      valid_d     = 1'b1;
      age_d       = '0;
    end

    if (tok_i.active) begin
      case (bcast_i.command)
        CMD_ANNOUNCE: begin
          first_free_d = !valid_q && !tok_i.free_seen;
          if (!valid_q) begin
            tok_d.free_seen = 1'b1;
          end
          if (match && !tok_i.hit) begin
            tok_d.hit   = 1'b1;
            write_entry = 1'b1;
            age_d       = '0;
          end
          tok_d.live = tok_i.live + LIVE_W'(valid_q);
        end
        CMD_TICK: begin
          if (valid_q) begin
            age_d = age_inc;
            if (age_inc >= bcast_i.timeout) begin
              valid_d       = 1'b0;
              tok_d.removed = 1'b1;
            end else begin
              tok_d.live = tok_i.live + LIVE_W'(1);
            end
          end
        end
        CMD_ELECT: begin
          if (valid_q && ((score_q > tok_i.lead_score) ||
              ((score_q == tok_i.lead_score) && (address_q < tok_i.best_address)))) begin
            tok_d.lead_score   = score_q;
            tok_d.best_address = address_q;
            tok_d.best_port    = port_q;
          end
          tok_d.live = tok_i.live + LIVE_W'(valid_q);
        end
        default: begin
          tok_d.live = tok_i.live + LIVE_W'(valid_q);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= 1'b0;
      first_free_q <= 1'b0;
      tok_q        <= '0;
    end else begin
      valid_q      <= valid_d;
      first_free_q <= first_free_d;
      tok_q        <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    age_q <= age_d;
    if (write_entry) begin
      address_q <= bcast_i.address;
      port_q    <= bcast_i.port;
      score_q   <= bcast_i.score;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- src/peer_table_leader_election.sv -----
// ----------------------------------------------------------------------------
// peer_table_leader_election: peer table with highest-score leader election
// A row of slot cells keeps the peer table. Every command sends one token
// down the row; each cell updates its entry and the token on the way.
// ----------------------------------------------------------------------------
//
//   Channel  | Handshake                  | Beat
//   ---------+----------------------------+-----------------------------------
//   command  | start / busy               | item_i (ptle_in_t)
//   result   | result_valid_o, one cycle  | result_o (ptle_out_t)
//   config   | cfg_we_i, cfg_idx_i        | cfg_data_i, no wait, no read-back
//
// A command beat is taken at a clock edge where start is high and busy is low.
// The token is registered by the launch register and by every slot cell; the
// result strobe is registered when it leaves the last cell, and busy drops at
// the same edge. A new command can be taken only once the walk has finished.
// The receiver cannot stall: the result is shown for exactly one cycle.
// After reset the table is empty, the role is discovering, the leader is
// zero and the expiry timeout is 30 ticks. No clearing pass is needed.
//
module peer_table_leader_election import ptle_pkg::*; #(
  parameter int unsigned PEER_SLOTS = PEER_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ptle_in_t              item_i,
  output logic                  result_valid_o,
  output ptle_out_t             result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } ptle_state_e;

  ptle_state_e state_q, state_d;

  // Configuration registers.
  logic [31:0] self_address_q;
  logic [15:0] self_port_q;
  logic [23:0] self_ram_mb_q;
  logic [9:0]  self_cores_q;
  logic [15:0] expiry_timeout_q;

  // Held command and the broadcast to the cells.
  logic [1:0]         cmd_q;
  logic [31:0]        peer_address_q;
  logic [15:0]        peer_port_q;
  logic [SCORE_W-1:0] peer_score_q;
  ptle_bcast_t        bcast;

  // Token chain: entry 0 is the launch register, the last entry leaves the row.
  ptle_tok_t tok_chain [PEER_SLOTS+1];
  ptle_tok_t launch_q, launch_d;
  ptle_tok_t tok_end;

  ptle_role_e  role_q, role_d;
  logic [31:0] winner_address_q, winner_address_d;
  logic [15:0] winner_port_q, winner_port_d;

  logic              accept;
  logic              done;
  logic              fill;
  logic              full;
  logic              changed;
  logic [LIVE_W-1:0] live_total;

  logic      result_valid_q;
  ptle_out_t result_q, result_d;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Configuration writes. Values wider than a register are cut to its width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_address_q   <= '0;
      self_port_q      <= '0;
      self_ram_mb_q    <= '0;
      self_cores_q     <= '0;
      expiry_timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SELF_ADDRESS:   self_address_q   <= cfg_data_i[31:0];
        REG_SELF_PORT:      self_port_q      <= cfg_data_i[15:0];
        REG_SELF_RAM_MB:    self_ram_mb_q    <= cfg_data_i[23:0];
        REG_SELF_CORES:     self_cores_q     <= cfg_data_i[9:0];
        REG_EXPIRY_TIMEOUT: expiry_timeout_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // The launch token starts the walk with self as the election candidate.
  always_comb begin
    launch_d = '0;
    if (accept) begin
      launch_d.active       = 1'b1;
      launch_d.lead_score   = score_of(self_ram_mb_q, self_cores_q);
      launch_d.best_address = self_address_q;
      launch_d.best_port    = self_port_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= launch_d;
    end
  end

  // The command and the peer fields stay fixed for the whole walk.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q          <= item_i.command;
      peer_address_q <= item_i.peer_address;
      peer_port_q    <= item_i.peer_port;
      peer_score_q   <= score_of(item_i.peer_ram_mb, item_i.peer_cores);
    end
  end

  assign tok_chain[0] = launch_q;
  assign tok_end      = tok_chain[PEER_SLOTS];
  assign done         = (state_q == ST_WALK) && tok_end.active;

  // A new peer takes the first free slot seen during the walk, if there is one.
  assign fill = done && (cmd_q == CMD_ANNOUNCE) && !tok_end.hit && tok_end.free_seen;
  assign full = done && (cmd_q == CMD_ANNOUNCE) && !tok_end.hit && !tok_end.free_seen;

  assign bcast.command = cmd_q;
  assign bcast.address = peer_address_q;
  assign bcast.port    = peer_port_q;
  assign bcast.score   = peer_score_q;
  assign bcast.timeout = expiry_timeout_q;
  assign bcast.fill    = fill;

  for (genvar g = 0; g < PEER_SLOTS; g++) begin : g_slot
    ptle_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .bcast_i(bcast),
      .tok_i  (tok_chain[g]),
      .tok_o  (tok_chain[g+1])
    );
  end

  assign live_total = tok_end.live + LIVE_W'(fill);

  // Election outcome and the topology flag, taken when the token leaves.
  always_comb begin
    role_d           = role_q;
    winner_address_d = winner_address_q;
    winner_port_d    = winner_port_q;
    changed          = 1'b0;
    case (cmd_q)
      CMD_TICK: begin
        changed = tok_end.removed;
      end
      CMD_ELECT: begin
        winner_address_d = tok_end.best_address;
        winner_port_d    = tok_end.best_port;
        if (tok_end.live == '0) begin
          role_d = ROLE_STANDALONE;
        end else if (tok_end.best_address == self_address_q) begin
          role_d = ROLE_COORDINATOR;
        end else begin
          role_d = ROLE_WORKER;
        end
        changed = (role_d != role_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    result_d.role             = role_d;
    result_d.leader_address   = winner_address_d;
    result_d.leader_port      = winner_port_d;
    result_d.live_peers       = (live_total > LIVE_W'(LIVE_OUT_MAX)) ? LIVE_OUT_MAX
                                                                     : live_total[4:0];
    result_d.topology_changed = changed;
    result_d.table_full       = full;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      role_q           <= ROLE_DISCOVERING;
      winner_address_q <= '0;
      winner_port_q    <= '0;
      result_valid_q   <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= done;
      if (done) begin
        role_q           <= role_d;
        winner_address_q <= winner_address_d;
        winner_port_q    <= winner_port_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule
